[hdl/sfir_pkg.sv]
// Shared types and constants for the stereo FIR filter unit.
// Used by sfir_front, sfir_back and stereo_fir_filter_unit; no dependencies.
package sfir_pkg;

  localparam int unsigned MaxTapsDefault = 256;
  localparam int unsigned SmpW           = 16;  // sample and coefficient width
  localparam int unsigned TapsW          = 9;   // tap count register width
  localparam int unsigned IdxInW         = 8;   // coefficient index field width

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  // One queued command: a coefficient pair for a load, a stereo sample otherwise
  typedef struct packed {
    op_e                     op;
    logic [IdxInW-1:0]       idx;
    logic signed [SmpW-1:0]  left;
    logic signed [SmpW-1:0]  right;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic finishing;
  } bk_stat_t;

endpackage

[hdl/sfir_front.sv]
// Front end of the stereo FIR filter: accepts input beats, classifies them
// and holds them in a two-entry command queue. Depends on sfir_pkg.
module sfir_front #(
  parameter int unsigned MAX_TAPS = sfir_pkg::MaxTapsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic [sfir_pkg::IdxInW-1:0]        coef_index_i,
  input  logic signed [sfir_pkg::SmpW-1:0]   left_coef_i,
  input  logic signed [sfir_pkg::SmpW-1:0]   right_coef_i,
  input  logic signed [sfir_pkg::SmpW-1:0]   left_sample_i,
  input  logic signed [sfir_pkg::SmpW-1:0]   right_sample_i,
  output logic                               q_valid_o,
  output sfir_pkg::cmd_t                     q_cmd_o,
  input  logic                               q_pop_i
);
  import sfir_pkg::*;

  cmd_t       cmd;
  logic       keep;
  logic       accept;
  logic       push;
  cmd_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign in_stall_o = (count_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && keep;

  always_comb begin
    cmd.op  = op_e'(operation_i);
    cmd.idx = coef_index_i;
    if (cmd.op == OP_LOAD) begin
      cmd.left  = left_coef_i;
      cmd.right = right_coef_i;
    end else begin
      cmd.left  = left_sample_i;
      cmd.right = right_sample_i;
    end
    // loads past the table end are taken and dropped
    keep = (cmd.op == OP_FILTER) || (32'(coef_index_i) < MAX_TAPS);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, q_pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign q_valid_o = (count_q != 2'd0);
  assign q_cmd_o   = slot_q[rd_ptr_q];

endmodule

[hdl/sfir_back.sv]
// Back end of the stereo FIR filter: coefficient and history memories, one
// MAC per tap per channel, rounding, saturation and the result register.
// Depends on sfir_pkg.
module sfir_back #(
  parameter int unsigned MAX_TAPS = sfir_pkg::MaxTapsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [sfir_pkg::TapsW-1:0]         taps_in_use_i,
  input  logic                               q_valid_i,
  input  sfir_pkg::cmd_t                     q_cmd_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [sfir_pkg::SmpW-1:0]   left_out_o,
  output logic signed [sfir_pkg::SmpW-1:0]   right_out_o,
  output logic                               clipped_o,
  output sfir_pkg::bk_stat_t                 stat_o
);
  import sfir_pkg::*;

  localparam int unsigned IdxW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CntW   = $clog2(MAX_TAPS + 1);
  localparam int unsigned CmpW   = (CntW > TapsW) ? CntW : TapsW;
  localparam int unsigned ProdW  = 2 * SmpW;
  localparam int unsigned AccW   = ProdW + $clog2(MAX_TAPS);
  localparam int unsigned FracW  = SmpW - 1;
  localparam int unsigned QW     = AccW - FracW;

  localparam logic [IdxW-1:0] LastAddr = IdxW'(MAX_TAPS - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(MAX_TAPS);
  localparam logic [AccW-1:0] Half     = AccW'(1) << (FracW - 1);
  localparam logic [SmpW-1:0] PosSat   = {1'b0, {(SmpW-1){1'b1}}};
  localparam logic [SmpW-1:0] NegSat   = {1'b1, {(SmpW-1){1'b0}}};
  localparam logic [QW-1:0]   QPos     = QW'(PosSat);
  localparam logic [QW-1:0]   QNeg     = QW'(NegSat);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ABS,
    ST_ROUND
  } state_e;

  state_e                  state_q;
  logic [IdxW-1:0]         k_q;
  logic [IdxW-1:0]         last_q;
  logic [IdxW-1:0]         rptr_q;
  logic [IdxW-1:0]         wptr_q;
  logic [IdxW-1:0]         wptr_nxt;
  logic [CntW-1:0]         fill_q;
  logic                    s1_vld_q;
  logic                    s1_live_q;
  logic                    s2_vld_q;
  logic                    out_valid_q;
  logic [SmpW-1:0]         left_out_q;
  logic [SmpW-1:0]         right_out_q;
  logic                    clipped_q;

  logic [2*SmpW-1:0]       coef_mem [MAX_TAPS];
  logic [2*SmpW-1:0]       hist_mem [MAX_TAPS];
  logic [2*SmpW-1:0]       coef_rd_q;
  logic [2*SmpW-1:0]       hist_rd_q;
  logic signed [SmpW-1:0]  coef_l;
  logic signed [SmpW-1:0]  coef_r;
  logic signed [SmpW-1:0]  hist_l;
  logic signed [SmpW-1:0]  hist_r;
  logic signed [ProdW-1:0] prod_l_q;
  logic signed [ProdW-1:0] prod_r_q;
  logic signed [AccW-1:0]  acc_l_q;
  logic signed [AccW-1:0]  acc_r_q;
  logic                    neg_l_q;
  logic                    neg_r_q;
  logic [AccW-1:0]         mag_l_q;
  logic [AccW-1:0]         mag_r_q;

  logic [CmpW-1:0]         taps_ext;
  logic [CmpW-1:0]         eff;
  logic [IdxW-1:0]         eff_last;
  logic                    start;
  logic                    coef_we;
  logic                    out_free;
  logic [SmpW:0]           res_l;
  logic [SmpW:0]           res_r;

  // {clip, value}: scale by 2^-15, round half away from zero, saturate
  function automatic logic [SmpW:0] round_sat(input logic neg, input logic [AccW-1:0] mag);
    logic [AccW-1:0] sum;
    logic [QW-1:0]   q;
    logic [SmpW:0]   res;
    sum = mag + Half;
    q   = sum[AccW-1:FracW];
    if (!neg && (q > QPos)) begin
      res = {1'b1, PosSat};
    end else if (neg && (q > QNeg)) begin
      res = {1'b1, NegSat};
    end else if (neg) begin
      res = {1'b0, -q[SmpW-1:0]};
    end else begin
      res = {1'b0, q[SmpW-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    taps_ext = CmpW'(taps_in_use_i);
    if (taps_ext == '0) begin
      eff = CmpW'(1);
    end else if (taps_ext > CmpW'(MAX_TAPS)) begin
      eff = CmpW'(MAX_TAPS);
    end else begin
      eff = taps_ext;
    end
    eff_last = IdxW'(eff - CmpW'(1));
  end

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign start    = q_pop_o && (q_cmd_i.op == OP_FILTER);
  assign coef_we  = q_pop_o && (q_cmd_i.op == OP_LOAD);
  assign wptr_nxt = (wptr_q == LastAddr) ? '0 : wptr_q + IdxW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  // history is a circular buffer; wptr_q points at the newest sample
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[IdxW'(q_cmd_i.idx)] <= {q_cmd_i.left, q_cmd_i.right};
    end
    coef_rd_q <= coef_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      hist_mem[wptr_nxt] <= {q_cmd_i.left, q_cmd_i.right};
    end
    hist_rd_q <= hist_mem[rptr_q];
  end

  assign coef_l = coef_rd_q[2*SmpW-1:SmpW];
  assign coef_r = coef_rd_q[SmpW-1:0];
  // entries older than the fill count still read as zero
  assign hist_l = s1_live_q ? hist_rd_q[2*SmpW-1:SmpW] : '0;
  assign hist_r = s1_live_q ? hist_rd_q[SmpW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_l_q <= coef_l * hist_l;
      prod_r_q <= coef_r * hist_r;
    end
    if (start) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (s2_vld_q) begin
      acc_l_q <= acc_l_q + AccW'(prod_l_q);
      acc_r_q <= acc_r_q + AccW'(prod_r_q);
    end
    if (state_q == ST_ABS) begin
      neg_l_q <= acc_l_q[AccW-1];
      neg_r_q <= acc_r_q[AccW-1];
      mag_l_q <= acc_l_q[AccW-1] ? -acc_l_q : acc_l_q;
      mag_r_q <= acc_r_q[AccW-1] ? -acc_r_q : acc_r_q;
    end
  end

  assign res_l = round_sat(neg_l_q, mag_l_q);
  assign res_r = round_sat(neg_r_q, mag_r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      last_q      <= '0;
      rptr_q      <= '0;
      wptr_q      <= '0;
      fill_q      <= '0;
      s1_vld_q    <= 1'b0;
      s1_live_q   <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      left_out_q  <= '0;
      right_out_q <= '0;
      clipped_q   <= 1'b0;
    end else begin
      s1_vld_q <= (state_q == ST_RUN);
      s2_vld_q <= s1_vld_q;
      if ((state_q == ST_ROUND) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            wptr_q <= wptr_nxt;
            rptr_q <= wptr_nxt;
            k_q    <= '0;
            last_q <= eff_last;
            if (fill_q != FullCnt) begin
              fill_q <= fill_q + CntW'(1);
            end
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          s1_live_q <= (CntW'(k_q) < fill_q);
          k_q       <= k_q + IdxW'(1);
          rptr_q    <= (rptr_q == '0) ? LastAddr : rptr_q - IdxW'(1);
          if (k_q == last_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_vld_q && !s2_vld_q) begin
            state_q <= ST_ABS;
          end
        end
        ST_ABS: begin
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          if (out_free) begin
            left_out_q  <= res_l[SmpW-1:0];
            right_out_q <= res_r[SmpW-1:0];
            clipped_q   <= res_l[SmpW] | res_r[SmpW];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_out_o       = left_out_q;
  assign right_out_o      = right_out_q;
  assign clipped_o        = clipped_q;
  assign stat_o.idle      = (state_q == ST_IDLE);
  assign stat_o.finishing = (state_q == ST_ROUND) && out_free;

endmodule

[hdl/stereo_fir_filter_unit.sv]
// Top level of the stereo FIR filter: tap count register, front queue and
// MAC back end. Depends on sfir_pkg, sfir_front and sfir_back.
//
//   channel | direction | handshake                      | payload
//   --------+-----------+--------------------------------+----------------------------------
//   in      | in        | in_valid_i / in_stall_o        | operation, coef_index, coefs, samples
//   out     | out       | out_valid_o / out_stall_i      | left_out, right_out, clipped
//   cfg     | in        | cfg_we_i (no wait)             | cfg_wdata_i = taps_in_use
//
// A filter beat runs one MAC per tap per channel in the back end, through the
// memory read and product stages, then abs and round; a load only writes a coefficient.
// The two-entry queue takes new beats while the back end works.
// Reset clears the sample history by fill count; coefficients are not reset.
// The back end holds in its rounding step while a finished result is stalled.
module stereo_fir_filter_unit #(
  parameter int unsigned MAX_TAPS = sfir_pkg::MaxTapsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sfir_pkg::TapsW-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic [sfir_pkg::IdxInW-1:0]        coef_index_i,
  input  logic signed [sfir_pkg::SmpW-1:0]   left_coef_i,
  input  logic signed [sfir_pkg::SmpW-1:0]   right_coef_i,
  input  logic signed [sfir_pkg::SmpW-1:0]   left_sample_i,
  input  logic signed [sfir_pkg::SmpW-1:0]   right_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [sfir_pkg::SmpW-1:0]   left_out_o,
  output logic signed [sfir_pkg::SmpW-1:0]   right_out_o,
  output logic                               clipped_o
);
  import sfir_pkg::*;

  logic [TapsW-1:0] taps_q;
  logic             q_valid;
  cmd_t             q_cmd;
  logic             q_pop;
  bk_stat_t         bk_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TapsW'(1);
    end else if (cfg_we_i) begin
      taps_q <= cfg_wdata_i;
    end
  end

  sfir_front #(
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .coef_index_i   (coef_index_i),
    .left_coef_i    (left_coef_i),
    .right_coef_i   (right_coef_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .q_valid_o      (q_valid),
    .q_cmd_o        (q_cmd),
    .q_pop_i        (q_pop)
  );

  sfir_back #(
    .MAX_TAPS(MAX_TAPS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .taps_in_use_i (taps_q),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .clipped_o     (clipped_o),
    .stat_o        (bk_stat)
  );

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_stall_means_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_valid)
    else $error("input stalled with an empty queue");

  a_result_from_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_stat.finishing))
    else $error("result appeared without a rounding step");

  a_round_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.finishing |=> out_valid_o)
    else $error("finished result was not registered");

  a_busy_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bk_stat.idle |-> !q_pop)
    else $error("queue popped while the back end was busy");

endmodule

[tb/tb_stereo_fir_filter_unit.sv]
// Self-checking testbench for stereo_fir_filter_unit: coefficient loads and
// stereo samples over several tap counts, checked against an in-bench predictor.
// Depends on sfir_pkg and the RTL of the filter unit only.
module tb_stereo_fir_filter_unit;
  import sfir_pkg::*;

  localparam int unsigned NTaps        = MaxTapsDefault;
  localparam int unsigned SettleCycles = NTaps + 16;

  typedef struct packed {
    op_e                    op;
    logic [IdxInW-1:0]      idx;
    logic signed [SmpW-1:0] l_coef;
    logic signed [SmpW-1:0] r_coef;
    logic signed [SmpW-1:0] l_smp;
    logic signed [SmpW-1:0] r_smp;
  } fir_beat_t;

  typedef struct packed {
    logic signed [SmpW-1:0] left;
    logic signed [SmpW-1:0] right;
    logic                   clipped;
  } fir_out_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   cfg_we_i       = 1'b0;
  logic [TapsW-1:0]       cfg_wdata_i    = '0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic                   operation_i    = 1'b0;
  logic [IdxInW-1:0]      coef_index_i   = '0;
  logic signed [SmpW-1:0] left_coef_i    = '0;
  logic signed [SmpW-1:0] right_coef_i   = '0;
  logic signed [SmpW-1:0] left_sample_i  = '0;
  logic signed [SmpW-1:0] right_sample_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic signed [SmpW-1:0] left_out_o;
  logic signed [SmpW-1:0] right_out_o;
  logic                   clipped_o;

  // predictor state
  logic signed [SmpW-1:0] hist_l [NTaps];
  logic signed [SmpW-1:0] hist_r [NTaps];
  logic signed [SmpW-1:0] coef_l [NTaps];
  logic signed [SmpW-1:0] coef_r [NTaps];
  logic [TapsW-1:0]       tap_count;

  // stimulus bookkeeping
  fir_beat_t beat_q [$];
  fir_out_t  filtered_q [$];
  fir_beat_t next_beat;
  bit        coef_set [NTaps];
  bit        in_beat_taken;
  bit        gaps_on;
  int        n_pushed, n_accepted, n_samples, n_loads, n_settings;
  int        n_checked, n_clipped, n_errors;

  stereo_fir_filter_unit #(
    .MAX_TAPS(NTaps)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .coef_index_i  (coef_index_i),
    .left_coef_i   (left_coef_i),
    .right_coef_i  (right_coef_i),
    .left_sample_i (left_sample_i),
    .right_sample_i(right_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .clipped_o     (clipped_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Q1.15 scaling: round half away from zero, then clamp to 16 bits
  function automatic logic signed [SmpW-1:0] round_clamp(input longint acc, inout logic clip);
    longint q;
    q = ((acc < 0 ? -acc : acc) + 16384) / 32768;
    if (acc < 0) q = -q;
    if (q > 32767) begin
      clip = 1'b1;
      return 16'sh7fff;
    end
    if (q < -32768) begin
      clip = 1'b1;
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  function automatic void fir_predict(input logic signed [SmpW-1:0] ls,
                                      input logic signed [SmpW-1:0] rs);
    longint   acc_l, acc_r;
    int       n;
    logic     clip;
    fir_out_t res;
    acc_l = 0;
    acc_r = 0;
    clip  = 1'b0;
    for (int k = NTaps - 1; k > 0; k--) begin
      hist_l[k] = hist_l[k-1];
      hist_r[k] = hist_r[k-1];
    end
    hist_l[0] = ls;
    hist_r[0] = rs;
    n = (tap_count == 0) ? 1 : (tap_count > NTaps) ? NTaps : int'(tap_count);
    for (int k = 0; k < n; k++) begin
      acc_l += longint'(coef_l[k]) * longint'(hist_l[k]);
      acc_r += longint'(coef_r[k]) * longint'(hist_r[k]);
    end
    res.left    = round_clamp(acc_l, clip);
    res.right   = round_clamp(acc_r, clip);
    res.clipped = clip;
    if (clip) n_clipped++;
    filtered_q.push_back(res);
  endfunction

  function automatic void check_field(input string what, input logic signed [SmpW-1:0] want,
                                      input logic signed [SmpW-1:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= 30)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // driver: new beat on the falling edge once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_beat_taken) begin
        if (beat_q.size() != 0 && !(gaps_on && $urandom_range(99) < 12)) begin
          next_beat = beat_q.pop_front();
          in_valid_i     <= 1'b1;
          operation_i    <= next_beat.op;
          coef_index_i   <= next_beat.idx;
          left_coef_i    <= next_beat.l_coef;
          right_coef_i   <= next_beat.r_coef;
          left_sample_i  <= next_beat.l_smp;
          right_sample_i <= next_beat.r_smp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= gaps_on && ($urandom_range(99) < 12);
    end
  end

  // monitor: checks output beats, feeds accepted input beats to the predictor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_beat_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 30)
            $display("%0t: output beat with none expected: left %0d right %0d clipped %0b",
                     $time, left_out_o, right_out_o, clipped_o);
        end else begin
          check_field("left_out", filtered_q[0].left, left_out_o);
          check_field("right_out", filtered_q[0].right, right_out_o);
          check_field("clipped", {15'd0, filtered_q[0].clipped}, {15'd0, clipped_o});
          void'(filtered_q.pop_front());
          n_checked++;
        end
      end
      if (cfg_we_i) tap_count = cfg_wdata_i;
      in_beat_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        n_accepted++;
        if (operation_i == OP_LOAD) begin
          coef_l[coef_index_i] = left_coef_i;
          coef_r[coef_index_i] = right_coef_i;
        end else begin
          fir_predict(left_sample_i, right_sample_i);
        end
      end
    end
  end

  function automatic logic signed [SmpW-1:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic logic signed [SmpW-1:0] pick_small(input int unsigned span);
    logic signed [SmpW-1:0] mag;
    mag = 16'($urandom_range(span));
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // mostly modest coefficients so long sums do not always clip
  function automatic logic signed [SmpW-1:0] pick_coef();
    case ($urandom_range(7))
      0, 1:    return 16'($urandom);
      2:       return pick_extreme();
      default: return pick_small(4096);
    endcase
  endfunction

  function automatic logic signed [SmpW-1:0] pick_sample();
    case ($urandom_range(9))
      7:       return pick_extreme();
      8, 9:    return pick_small(256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_load(input logic [IdxInW-1:0] idx, input logic signed [SmpW-1:0] lc,
                           input logic signed [SmpW-1:0] rc);
    fir_beat_t b;
    b = '{op: OP_LOAD, idx: idx, l_coef: lc, r_coef: rc,
          l_smp: 16'($urandom), r_smp: 16'($urandom)};
    beat_q.push_back(b);
    coef_set[idx] = 1'b1;
    n_pushed++;
    n_loads++;
  endtask

  task automatic push_sample(input logic signed [SmpW-1:0] ls,
                             input logic signed [SmpW-1:0] rs);
    fir_beat_t b;
    b = '{op: OP_FILTER, idx: 8'($urandom), l_coef: 16'($urandom), r_coef: 16'($urandom),
          l_smp: ls, r_smp: rs};
    beat_q.push_back(b);
    n_pushed++;
    n_samples++;
  endtask

  // all beats taken and all outputs seen, then room for trailing loads
  task automatic wait_quiet();
    do @(negedge clk_i); while (n_accepted != n_pushed || filtered_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_taps(input logic [TapsW-1:0] v);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input logic [TapsW-1:0] tv, input int budget);
    int                eff, fills, n;
    logic [IdxInW-1:0] idx;
    set_taps(tv);
    eff   = (tv == 0) ? 1 : (tv > NTaps) ? NTaps : int'(tv);
    fills = 0;
    // every tap in use must hold a written coefficient before a sample arrives
    for (int k = 0; k < eff; k++) begin
      if (!coef_set[k]) begin
        push_load(8'(k), pick_coef(), pick_coef());
        fills++;
      end
    end
    n = (budget > fills + 20) ? budget - fills : 20;
    repeat (n) begin
      if ($urandom_range(99) < 25) begin
        idx = $urandom_range(1) ? 8'($urandom_range(eff - 1)) : 8'($urandom_range(255));
        push_load(idx, pick_coef(), pick_coef());
      end else begin
        push_sample(pick_sample(), pick_sample());
      end
    end
  endtask

  initial begin
    for (int k = 0; k < NTaps; k++) begin
      hist_l[k]   = '0;
      hist_r[k]   = '0;
      coef_l[k]   = '0;
      coef_r[k]   = '0;
      coef_set[k] = 1'b0;
    end
    tap_count = 9'd1;
    gaps_on   = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset tap count of one, clipping at both ends, rounding of halves
    push_load(8'd0, 16'sh8000, 16'sh7fff);
    push_sample(16'sh8000, 16'sh8000);
    push_load(8'd0, 16'sd1, 16'sd1);
    push_sample(16'sd16384, -16'sd16384);
    push_sample(16'sd16383, -16'sd16383);
    push_sample(-16'sd16385, 16'sd16385);
    push_load(8'd0, 16'sh7fff, 16'sh8000);
    push_sample(16'sh7fff, 16'sh7fff);
    push_sample(16'sd0, -16'sd1);
    push_load(8'd255, 16'sh7fff, 16'sh8000);
    set_taps(9'd0);  // zero taps behaves as one
    push_sample(16'sd100, -16'sd100);
    push_sample(16'sh8000, 16'sh7fff);
    set_taps(9'd2);
    push_load(8'd0, 16'sh8000, 16'sh8000);
    push_load(8'd1, 16'sh8000, 16'sh8000);
    push_sample(16'sh7fff, 16'sh7fff);
    push_sample(16'sh7fff, 16'sh7fff);
    push_sample(16'sh8000, 16'sh8000);

    run_phase(9'd4, 140);
    run_phase(9'd256, 60);
    run_phase(9'd17, 140);
    run_phase(9'd511, 60);
    run_phase(9'd0, 140);
    gaps_on = 1'b0;
    run_phase(9'd64, 140);
    gaps_on = 1'b1;
    run_phase(9'd257, 60);
    run_phase(9'd9, 140);
    run_phase(9'd128, 60);
    run_phase(9'd2, 140);
    run_phase(9'd33, 140);
    run_phase(9'd170, 60);

    wait_quiet();
    $display("covered %0d sample beats and %0d coefficient loads over %0d tap settings",
             n_samples, n_loads, n_settings);
    $display("checked %0d output beats, %0d of them saturated", n_checked, n_clipped);
    if (n_errors == 0) begin
      $display("tb_stereo_fir_filter_unit: done, clean");
    end else begin
      $display("tb_stereo_fir_filter_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #(8 * 1500000);
    $display("timeout: %0d of %0d beats taken, %0d outputs outstanding",
             n_accepted, n_pushed, filtered_q.size());
    $display("tb_stereo_fir_filter_unit: done, errors");
    $finish;
  end

endmodule

[filelist.f]
hdl/sfir_pkg.sv
hdl/sfir_front.sv
hdl/sfir_back.sv
hdl/stereo_fir_filter_unit.sv
tb/tb_stereo_fir_filter_unit.sv
